// ----- sv/u8u16_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

   localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
   localparam logic [15:0] HI_SURR     = 16'hD800;
   localparam logic [15:0] LO_SURR     = 16'hDC00;
   localparam logic [20:0] SUPP_BASE   = 21'h10000;
   localparam logic [20:0] CP_MAX      = 21'h10FFFF;
   localparam logic [15:0] SURR_FIRST  = 16'hD800;
   localparam logic [15:0] SURR_LAST   = 16'hDFFF;
   localparam logic [15:0] THREE_MIN   = 16'h0800;
   localparam logic [10:0] TWO_MIN     = 11'h080;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOW,
      ST_FLUSH
   } seq_state_type;

   // What the decode unit makes of the sequence at the head of the buffer.
   typedef struct packed {
      logic        emit;        // one code unit is produced
      logic        pair;        // a low surrogate follows the unit
      logic        incomplete;  // the sequence runs past the buffered bytes
      logic [15:0] unit;
      logic [15:0] low_unit;
      logic [2:0]  consume;     // bytes taken from the head of the buffer
   } dec_result_type;

endpackage

// ----- sv/u8u16_decode.sv -----
// Decode unit: examines the UTF-8 sequence at the head of the byte buffer.
module u8u16_decode (
   input  logic [7:0]               b0,
   input  logic [7:0]               b1,
   input  logic [7:0]               b2,
   input  logic [7:0]               b3,
   input  logic [2:0]               avail,
   input  logic                     last,
   output u8u16_pkg::dec_result_type result
);

   logic [2:0]  need;
   logic        lead_ok;
   logic        c1;
   logic        c2;
   logic        c3;
   logic [10:0] cp2;
   logic [15:0] cp3;
   logic [20:0] cp4;
   logic [19:0] v4;
   logic        bad;

   assign c1  = (b1[7:6] == 2'b10);
   assign c2  = (b2[7:6] == 2'b10);
   assign c3  = (b3[7:6] == 2'b10);
   assign cp2 = {b0[4:0], b1[5:0]};
   assign cp3 = {b0[3:0], b1[5:0], b2[5:0]};
   assign cp4 = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
   assign v4  = 20'(cp4 - u8u16_pkg::SUPP_BASE);

   always_comb begin
      lead_ok = 1'b1;
      need    = 3'd1;
      if (b0[7] == 1'b0) begin
         need = 3'd1;
      end else if (b0[7:5] == 3'b110) begin
         need = 3'd2;
      end else if (b0[7:4] == 4'b1110) begin
         need = 3'd3;
      end else if (b0[7:3] == 5'b11110) begin
         need = 3'd4;
      end else begin
         lead_ok = 1'b0;
      end
   end

   always_comb begin
      case (need)
         3'd2:    bad = !c1 || (cp2 < u8u16_pkg::TWO_MIN);
         3'd3:    bad = !c1 || !c2 || (cp3 < u8u16_pkg::THREE_MIN) ||
                        (cp3 inside {[u8u16_pkg::SURR_FIRST:u8u16_pkg::SURR_LAST]});
         3'd4:    bad = !c1 || !c2 || !c3 || (cp4 < u8u16_pkg::SUPP_BASE) ||
                        (cp4 > u8u16_pkg::CP_MAX);
         default: bad = 1'b0;
      endcase
   end

   always_comb begin
      result            = '0;
      result.unit       = u8u16_pkg::REPL_UNIT;
      result.consume    = 3'd1;
      if (!lead_ok) begin
         result.emit = 1'b1;
      end else if (need > avail) begin
         result.incomplete = 1'b1;
         result.emit       = last;
      end else if (bad) begin
         result.emit = 1'b1;
      end else begin
         result.emit    = 1'b1;
         result.consume = need;
         case (need)
            3'd1: begin
               if (b0 != 8'h00) begin
                  result.unit = {8'h00, b0};
               end
            end
            3'd2:    result.unit = {5'b00000, cp2};
            3'd3:    result.unit = cp3;
            default: begin
               result.pair     = 1'b1;
               result.unit     = u8u16_pkg::HI_SURR | {6'b000000, v4[19:10]};
               result.low_unit = u8u16_pkg::LO_SURR | {6'b000000, v4[9:0]};
            end
         endcase
      end
   end

endmodule

// ----- sv/utf8_to_utf16_transcoder.sv -----
// Top level of the UTF-8 to UTF-16 transcoder: byte buffer, sequencer, held word and output word register.
// An accepted byte is loaded in the idle state, then each sequence or low surrogate is handled
// in turn by the shared decode unit, and the held word is released at the end. A byte's first
// result word passes through the held-word register into the output word register, and a
// stalled result channel holds the sequencer.
// Synchronous active-high reset clears the sequencer, pending-byte count, held-word valid and output valid.
module utf8_to_utf16_transcoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_utf16_unit,
   output logic        rsp_out_last
);

   // Sequencer state. avail_ff counts the valid bytes at the head of the buffer; between
   // bytes it is the number of pending bytes of an unfinished sequence (at most three).
   u8u16_pkg::seq_state_type state_ff, state_in;
   logic [7:0]  buf_ff [4];
   logic [7:0]  buf_in [4];
   logic [2:0]  avail_ff, avail_in;
   logic        last_ff, last_in;
   logic [15:0] low_ff, low_in;

   // The newest word is held back one step so that the end-of-string flag can be put on
   // the truly final word of the string, which is known only once the buffer runs dry.
   logic        hold_v_ff, hold_v_in;
   logic [15:0] hold_ff, hold_in;

   // Output word register.
   logic        rsp_valid_ff;
   logic [15:0] rsp_unit_ff;
   logic        rsp_last_ff;

   logic        can_push;
   logic        push;
   logic [15:0] push_unit;
   logic        push_last;

   u8u16_pkg::dec_result_type dec;

   u8u16_decode u_decode (
      .b0     (buf_ff[0]),
      .b1     (buf_ff[1]),
      .b2     (buf_ff[2]),
      .b3     (buf_ff[3]),
      .avail  (avail_ff),
      .last   (last_ff),
      .result (dec)
   );

   assign can_push = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      buf_in    = buf_ff;
      avail_in  = avail_ff;
      last_in   = last_ff;
      low_in    = low_ff;
      hold_v_in = hold_v_ff;
      hold_in   = hold_ff;
      push      = 1'b0;
      push_unit = hold_ff;
      push_last = 1'b0;
      req_ready = 1'b0;

      case (state_ff)
         u8u16_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               buf_in[avail_ff[1:0]] = req_in_byte;
               avail_in              = avail_ff + 3'd1;
               last_in               = req_in_last;
               state_in              = u8u16_pkg::ST_DECODE;
            end
         end

         u8u16_pkg::ST_DECODE: begin
            if (can_push) begin
               if (dec.emit) begin
                  // The earlier held word cannot be the last one any more.
                  push      = hold_v_ff;
                  hold_v_in = 1'b1;
                  hold_in   = dec.unit;
               end
               if (dec.incomplete) begin
                  // At the end of the string the tail is dropped; otherwise it waits.
                  if (last_ff) begin
                     avail_in = 3'd0;
                  end
                  state_in = u8u16_pkg::ST_FLUSH;
               end else begin
                  case (dec.consume)
                     3'd1: begin
                        buf_in[0] = buf_ff[1];
                        buf_in[1] = buf_ff[2];
                        buf_in[2] = buf_ff[3];
                     end
                     3'd2: begin
                        buf_in[0] = buf_ff[2];
                        buf_in[1] = buf_ff[3];
                     end
                     3'd3: begin
                        buf_in[0] = buf_ff[3];
                     end
                     default: begin
                        buf_in = buf_ff;
                     end
                  endcase
                  avail_in = avail_ff - dec.consume;
                  if (dec.pair) begin
                     low_in   = dec.low_unit;
                     state_in = u8u16_pkg::ST_LOW;
                  end else if (avail_in == 3'd0) begin
                     state_in = u8u16_pkg::ST_FLUSH;
                  end
               end
            end
         end

         u8u16_pkg::ST_LOW: begin
            if (can_push) begin
               push    = 1'b1;
               hold_in = low_ff;
               if (avail_ff == 3'd0) begin
                  state_in = u8u16_pkg::ST_FLUSH;
               end else begin
                  state_in = u8u16_pkg::ST_DECODE;
               end
            end
         end

         u8u16_pkg::ST_FLUSH: begin
            if (!hold_v_ff) begin
               state_in = u8u16_pkg::ST_IDLE;
            end else if (can_push) begin
               push      = 1'b1;
               push_last = last_ff;
               hold_v_in = 1'b0;
               state_in  = u8u16_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = u8u16_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= u8u16_pkg::ST_IDLE;
         avail_ff     <= 3'd0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         avail_ff  <= avail_in;
         hold_v_ff <= hold_v_in;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      buf_ff  <= buf_in;
      last_ff <= last_in;
      low_ff  <= low_in;
      hold_ff <= hold_in;
      if (push) begin
         rsp_unit_ff <= push_unit;
         rsp_last_ff <= push_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_utf16_unit = rsp_unit_ff;
   assign rsp_out_last   = rsp_last_ff;

endmodule

// ----- tb/tb_utf8_to_utf16_transcoder.sv -----
// Self-checking testbench for the UTF-8 to UTF-16 transcoder, with a scoreboard class.
`timescale 1ns / 100ps

module tb_utf8_to_utf16_transcoder;

   // One result word as it leaves the block: a code unit and its end-of-string flag.
   typedef struct packed {
      logic [15:0] unit;
      logic        last;
   } utf16_word_type;

   // The scoreboard keeps its own copy of the pending-byte buffer, decodes each accepted
   // input word exactly as the block should, and queues the code units that must follow.
   class utf16_unit_scoreboard_type;
      logic [7:0]     held_bytes [3];
      int             held_count;
      utf16_word_type expected_units [$];
      int             errors;

      function new();
         held_bytes[0] = 8'h00;
         held_bytes[1] = 8'h00;
         held_bytes[2] = 8'h00;
         held_count = 0;
         errors = 0;
      endfunction

      function int outstanding();
         return expected_units.size();
      endfunction

      // Decodes the held bytes plus the newly accepted byte and queues the units they give.
      function void predict_units(logic [7:0] in_byte, logic in_last);
         logic [7:0]     window [4];
         logic [15:0]    units [4];
         logic [7:0]     b0;
         logic [20:0]    cp;
         logic [20:0]    offset;
         logic           bad;
         logic           hold;
         int             n;
         int             pos;
         int             need;
         int             k;
         int             i;
         utf16_word_type word;
         n = held_count;
         for (i = 0; i < n; i++) window[i] = held_bytes[i];
         window[n] = in_byte;
         n++;
         pos = 0;
         k = 0;
         hold = 1'b0;
         while (pos < n) begin
            b0 = window[pos];
            if (b0[7] == 1'b0) need = 1;
            else if (b0[7:5] == 3'b110) need = 2;
            else if (b0[7:4] == 4'b1110) need = 3;
            else if (b0[7:3] == 5'b11110) need = 4;
            else begin
               // Stray continuation byte or a lead that no sequence may start with.
               units[k] = u8u16_pkg::REPL_UNIT;
               k++;
               pos++;
               continue;
            end
            if (pos + need > n) begin
               if (in_last) begin
                  units[k] = u8u16_pkg::REPL_UNIT;
                  k++;
                  pos = n;
               end else begin
                  hold = 1'b1;
               end
               break;
            end
            bad = 1'b0;
            cp = '0;
            case (need)
               1: cp = {14'd0, b0[6:0]};
               2: begin
                  bad = (window[pos+1][7:6] != 2'b10);
                  cp = {10'd0, b0[4:0], window[pos+1][5:0]};
                  if (!bad && cp < u8u16_pkg::TWO_MIN) bad = 1'b1;
               end
               3: begin
                  bad = (window[pos+1][7:6] != 2'b10) || (window[pos+2][7:6] != 2'b10);
                  cp = {5'd0, b0[3:0], window[pos+1][5:0], window[pos+2][5:0]};
                  if (!bad && (cp < u8u16_pkg::THREE_MIN ||
                               cp inside {[u8u16_pkg::SURR_FIRST:u8u16_pkg::SURR_LAST]}))
                     bad = 1'b1;
               end
               default: begin
                  bad = (window[pos+1][7:6] != 2'b10) || (window[pos+2][7:6] != 2'b10)
                     || (window[pos+3][7:6] != 2'b10);
                  cp = {b0[2:0], window[pos+1][5:0], window[pos+2][5:0], window[pos+3][5:0]};
                  if (!bad && (cp < u8u16_pkg::SUPP_BASE || cp > u8u16_pkg::CP_MAX))
                     bad = 1'b1;
               end
            endcase
            if (bad) begin
               // Only the lead is dropped; what follows is looked at again as a lead.
               units[k] = u8u16_pkg::REPL_UNIT;
               k++;
               pos++;
               continue;
            end
            if (cp == '0) begin
               units[k] = u8u16_pkg::REPL_UNIT;
               k++;
            end else if (cp < u8u16_pkg::SUPP_BASE) begin
               units[k] = cp[15:0];
               k++;
            end else begin
               offset = cp - u8u16_pkg::SUPP_BASE;
               units[k] = u8u16_pkg::HI_SURR | {6'd0, offset[19:10]};
               units[k+1] = u8u16_pkg::LO_SURR | {6'd0, offset[9:0]};
               k += 2;
            end
            pos += need;
         end
         if (hold) begin
            for (i = 0; i < n - pos; i++) held_bytes[i] = window[pos + i];
            held_count = n - pos;
         end else begin
            held_count = 0;
         end
         for (i = 0; i < k; i++) begin
            word.unit = units[i];
            word.last = in_last && (i == k - 1);
            expected_units.insert(expected_units.size(), word);
         end
      endfunction

      // Compares one accepted result word with the oldest expectation.
      function void check_unit(logic [15:0] unit, logic last);
         utf16_word_type want;
         if (expected_units.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual unit %h last %b",
                     $time, unit, last);
            errors++;
         end else begin
            want = expected_units.pop_front();
            if (unit !== want.unit) begin
               $display("%0t: utf16_unit mismatch, expected %h, actual %h",
                        $time, want.unit, unit);
               errors++;
            end
            if (last !== want.last) begin
               $display("%0t: out_last mismatch, expected %b, actual %b",
                        $time, want.last, last);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        req_in_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_utf16_unit;
   logic        rsp_out_last;

   // Chance in a hundred, per cycle, that the sender or the receiver idles.
   int send_idle_pct;
   int recv_idle_pct;

   // The byte sequence about to be sent, built by the directed or the random part.
   logic [7:0] utf8_seq [$];

   utf16_unit_scoreboard_type scoreboard = new();

   utf8_to_utf16_transcoder uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_utf16_unit (rsp_utf16_unit),
      .rsp_out_last   (rsp_out_last)
   );

   // A 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sends one input word. Idle cycles, if any, come before valid is raised; valid is left
   // high after acceptance so that back-to-back words need no second assignment in a step.
   // Outputs are sampled just after the edge, so they hold their values from before it.
   task automatic send_byte(input logic [7:0] value, input logic end_of_string);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= value;
      req_in_last <= end_of_string;
      do @(posedge clock); while (!req_ready);
      scoreboard.predict_units(value, end_of_string);
   endtask

   // Sends the whole of utf8_seq, flagging its final byte as the end of the string if asked.
   task automatic send_utf8_seq(input logic end_of_string);
      int i;
      for (i = 0; i < utf8_seq.size(); i++)
         send_byte(utf8_seq[i], end_of_string && (i == utf8_seq.size() - 1));
   endtask

   // Holds the sender back until every expected result word has been taken. The count is
   // read on the falling edge, away from the receiver's updates, then the edge is regained.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (scoreboard.outstanding() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Builds one random sequence into utf8_seq. Most are plain encodings of code points of every
   // length (three-byte ones may fall in the surrogate range); the rest are truncated or corrupted
   // sequences, overlong or out-of-range forms and plain noise. Returns whether the sequence should end the string.
   task automatic build_random_seq(output logic end_of_string);
      int          kind;
      int          len;
      int          i;
      logic [20:0] cp;
      logic [7:0]  noise;
      logic [7:0]  leads [8];
      leads = '{8'hC0, 8'hC1, 8'hE0, 8'hF0, 8'hF4, 8'hF5, 8'hF6, 8'hF7};
      kind = $urandom_range(99);
      len = $urandom_range(4, 1);
      case (len)
         1: cp = 21'($urandom_range(21'h7F, 21'h0));
         2: cp = 21'($urandom_range(21'h7FF, 21'h80));
         3: cp = 21'($urandom_range(21'hFFFF, 21'h800));
         default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
      endcase
      utf8_seq.delete();
      case (len)
         1: utf8_seq.insert(utf8_seq.size(), {1'b0, cp[6:0]});
         2: begin
            utf8_seq.insert(utf8_seq.size(), {3'b110, cp[10:6]});
            utf8_seq.insert(utf8_seq.size(), {2'b10, cp[5:0]});
         end
         3: begin
            utf8_seq.insert(utf8_seq.size(), {4'b1110, cp[15:12]});
            utf8_seq.insert(utf8_seq.size(), {2'b10, cp[11:6]});
            utf8_seq.insert(utf8_seq.size(), {2'b10, cp[5:0]});
         end
         default: begin
            utf8_seq.insert(utf8_seq.size(), {5'b11110, cp[20:18]});
            utf8_seq.insert(utf8_seq.size(), {2'b10, cp[17:12]});
            utf8_seq.insert(utf8_seq.size(), {2'b10, cp[11:6]});
            utf8_seq.insert(utf8_seq.size(), {2'b10, cp[5:0]});
         end
      endcase
      if (kind inside {[60:74]}) begin
         if (len == 1) begin
            noise = 8'($urandom);
            utf8_seq.insert(utf8_seq.size(), {2'b10, noise[5:0]});
         end else if ($urandom_range(1)) begin
            // A continuation byte that is not one.
            noise = 8'($urandom);
            if (noise[7:6] == 2'b10) noise[6] = 1'b1;
            utf8_seq[$urandom_range(len - 1, 1)] = noise;
         end else begin
            // A truncated sequence, often right at the end of the string.
            for (i = $urandom_range(len - 1, 1); i > 0; i--) void'(utf8_seq.pop_back());
         end
      end else if (kind inside {[75:84]}) begin
         utf8_seq.delete();
         utf8_seq.insert(utf8_seq.size(), leads[$urandom_range(7)]);
         len = (utf8_seq[0][7:5] == 3'b110) ? 2 : (utf8_seq[0][7:4] == 4'b1110) ? 3 : 4;
         for (i = 1; i < len; i++) begin
            noise = 8'($urandom);
            utf8_seq.insert(utf8_seq.size(), {2'b10, noise[5:0]});
         end
      end else if (kind >= 85) begin
         utf8_seq.delete();
         for (i = $urandom_range(3, 1); i > 0; i--)
            utf8_seq.insert(utf8_seq.size(), 8'($urandom));
      end
      end_of_string = (kind inside {[60:74]}) ? ($urandom_range(1) == 1)
                                              : ($urandom_range(5) == 0);
   endtask

   // Receiver: a result word is taken at each edge where valid and ready were both high,
   // and ready is redrawn for the next cycle.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            scoreboard.check_unit(rsp_utf16_unit, rsp_out_last);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Stimulus and verdict.
   initial begin
      int   phase;
      int   random_bytes;
      logic end_of_string;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      req_in_last = 1'b0;
      send_idle_pct = 34;
      recv_idle_pct = 57;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. ASCII with NUL and the top of the ASCII range, ending the string.
      utf8_seq = '{8'h41, 8'h00, 8'h7F};
      send_utf8_seq(1'b1);
      // A plain two-byte form, then an overlong one whose lead alone is dropped.
      utf8_seq = '{8'hC2, 8'hA9};
      send_utf8_seq(1'b0);
      utf8_seq = '{8'hC1, 8'hBF};
      send_utf8_seq(1'b0);
      // A three-byte form, then one that encodes a surrogate.
      utf8_seq = '{8'hE2, 8'h82, 8'hAC};
      send_utf8_seq(1'b0);
      utf8_seq = '{8'hED, 8'hA0, 8'h80};
      send_utf8_seq(1'b0);
      // A four-byte form giving a surrogate pair on the last word of the string.
      utf8_seq = '{8'hF0, 8'h9F, 8'h98, 8'h80};
      send_utf8_seq(1'b1);
      // A value above the top of the code space, then a lead that is never valid.
      utf8_seq = '{8'hF4, 8'h90, 8'h80, 8'h80};
      send_utf8_seq(1'b0);
      utf8_seq = '{8'hFF};
      send_utf8_seq(1'b0);
      // A bad continuation byte, which is then decoded as a lead of its own.
      utf8_seq = '{8'hC3, 8'h41};
      send_utf8_seq(1'b0);
      // A sequence left unfinished when the string ends.
      utf8_seq = '{8'hE2, 8'h82};
      send_utf8_seq(1'b1);

      // Random part in three idling phases, with the pipeline drained between them.
      for (phase = 0; phase < 3; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               send_idle_pct = 34;
               recv_idle_pct = 57;
            end
            1: begin
               send_idle_pct = 57;
               recv_idle_pct = 34;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         random_bytes = 0;
         while (random_bytes < 58) begin
            build_random_seq(end_of_string);
            random_bytes += utf8_seq.size();
            send_utf8_seq(end_of_string);
         end
      end

      // Let the last words drain, then keep watching for anything spurious before the verdict.
      wait_drained();
      repeat (16) @(posedge clock);
      if (scoreboard.errors == 0 && scoreboard.outstanding() == 0) begin
         $display("utf8_to_utf16_transcoder verification clean");
      end else begin
         $display("utf8_to_utf16_transcoder verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("utf8_to_utf16_transcoder verification failed");
      $finish;
   end

endmodule
